// ===== hw/rtl/fpe_pkg.sv =====
`default_nettype none

package fpe_pkg;

  // field widths
  localparam int ADDR_W = 24;
  localparam int LEN_W  = 22;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 9;

  // flash geometry and limits
  localparam int PAGE_BYTES    = 256;
  localparam int FLASH_BYTES   = 2097152;
  localparam int MAX_WRITE_LEN = 16128;
  localparam int MAX_RESULTS   = 64;

  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int TOT_W  = $clog2(MAX_RESULTS + 1);

  // erase granule shifts: 64 KB block, 32 KB block, 4 KB sector
  localparam int E64_SHIFT = 16;
  localparam int E32_SHIFT = 15;
  localparam int E4_SHIFT  = 12;
  localparam int N64_W     = LEN_W - E64_SHIFT;
  localparam int N4_W      = E32_SHIFT + 1 - E4_SHIFT;

  // request types
  localparam logic REQ_PROGRAM = 1'b0;
  localparam logic REQ_ERASE   = 1'b1;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_PROG    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_E64     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_E32     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_E4      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOTHING = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  length;
  } fpe_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] command_kind;
    logic [ADDR_W-1:0] command_address;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } fpe_cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic plan;
    logic emit;
  } fpe_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic cur_last;
  } fpe_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpe_ctrl.sv =====
`default_nettype none

module fpe_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire fpe_pkg::fpe_stat_t stat_i,
  output fpe_pkg::fpe_ctrl_t      ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PLAN = 3'b010,
    ST_RUN  = 3'b100
  } fpe_state_e;

  fpe_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_PLAN;
        end
      end
      ST_PLAN: begin
        ctrl_o.plan = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          ctrl_o.emit = 1'b1;
          if (stat_i.cur_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpe_datapath.sv =====
`default_nettype none

module fpe_datapath #(
  parameter int PAGE_BYTES    = fpe_pkg::PAGE_BYTES,
  parameter int FLASH_BYTES   = fpe_pkg::FLASH_BYTES,
  parameter int MAX_WRITE_LEN = fpe_pkg::MAX_WRITE_LEN
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire fpe_pkg::fpe_ctrl_t ctrl_i,
  input  wire fpe_pkg::fpe_req_t  req_i,
  input  wire                     out_stall_i,
  output fpe_pkg::fpe_stat_t      stat_o,
  output logic                    out_valid_o,
  output fpe_pkg::fpe_cmd_t       out_cmd_o
);

  localparam int SUM_W  = fpe_pkg::ADDR_W + 1;
  localparam int PG_W   = fpe_pkg::LEN_W + 1;
  localparam int E4_W   = fpe_pkg::E32_SHIFT + 1;
  localparam int PAGE_W = $clog2(PAGE_BYTES);

  // request as taken
  logic                                 type_q;
  logic [fpe_pkg::ADDR_W-1:0]           addr_q;
  logic [fpe_pkg::LEN_W-1:0]            len_q;

  // plan state
  logic                                 single_q;
  logic [fpe_pkg::KIND_W-1:0]           single_kind_q;
  logic [fpe_pkg::CNT_W-1:0]            chunk_q;
  logic [fpe_pkg::LEN_W-1:0]            rest_q;
  logic [fpe_pkg::N64_W-1:0]            n64_q;
  logic                                 n32_q;
  logic [fpe_pkg::TOT_W-1:0]            tot_q;

  logic                                 out_valid_q;
  fpe_pkg::fpe_cmd_t                    out_cmd_q;

  // planning
  logic [SUM_W-1:0]                     end_sum;
  logic                                 out_of_range;
  logic [fpe_pkg::CNT_W-1:0]            room;
  logic [fpe_pkg::CNT_W-1:0]            first_chunk;
  logic [fpe_pkg::LEN_W-1:0]            first_rest;
  logic [PG_W-1:0]                      prog_pages;
  logic                                 prog_reject;
  logic [fpe_pkg::N64_W-1:0]            e_n64;
  logic                                 e_n32;
  logic [E4_W-1:0]                      e_n4_sum;
  logic [fpe_pkg::N4_W-1:0]             e_n4;
  logic [fpe_pkg::TOT_W-1:0]            e_total;
  logic                                 erase_reject;
  logic                                 erase_none;
  logic                                 plan_reject;

  always_comb begin
    end_sum      = SUM_W'(addr_q) + SUM_W'(len_q);
    out_of_range = (SUM_W'(addr_q) > SUM_W'(FLASH_BYTES)) ||
                   (end_sum > SUM_W'(FLASH_BYTES));

    room        = fpe_pkg::CNT_W'(PAGE_BYTES) -
                  fpe_pkg::CNT_W'(addr_q[PAGE_W-1:0]);
    first_chunk = (len_q < fpe_pkg::LEN_W'(room)) ? len_q[fpe_pkg::CNT_W-1:0] : room;
    first_rest  = len_q - fpe_pkg::LEN_W'(first_chunk);
    prog_pages  = (PG_W'(first_rest) + PG_W'(PAGE_BYTES - 1)) >> PAGE_W;
    prog_reject = (len_q > fpe_pkg::LEN_W'(MAX_WRITE_LEN)) ||
                  (prog_pages > PG_W'(fpe_pkg::MAX_RESULTS - 1));

    e_n64        = len_q[fpe_pkg::LEN_W-1:fpe_pkg::E64_SHIFT];
    e_n32        = len_q[fpe_pkg::E32_SHIFT];
    e_n4_sum     = E4_W'(len_q[fpe_pkg::E32_SHIFT-1:0]) +
                   E4_W'((1 << fpe_pkg::E4_SHIFT) - 1);
    e_n4         = e_n4_sum[E4_W-1:fpe_pkg::E4_SHIFT];
    e_total      = fpe_pkg::TOT_W'(e_n64) + fpe_pkg::TOT_W'(e_n32) +
                   fpe_pkg::TOT_W'(e_n4);
    erase_reject = (e_total > fpe_pkg::TOT_W'(fpe_pkg::MAX_RESULTS));
    erase_none   = (e_total == '0);

    plan_reject = out_of_range ||
                  ((type_q == fpe_pkg::REQ_PROGRAM) ? prog_reject : erase_reject);
  end

  // current command
  fpe_pkg::fpe_cmd_t                    cur;
  logic [fpe_pkg::ADDR_W-1:0]           step;
  logic [fpe_pkg::CNT_W-1:0]            next_chunk;

  always_comb begin
    cur.command_address = addr_q;
    cur.byte_count      = '0;
    step                = '0;
    if (single_q) begin
      cur.command_kind = single_kind_q;
      cur.last         = 1'b1;
    end else if (type_q == fpe_pkg::REQ_PROGRAM) begin
      cur.command_kind = fpe_pkg::KIND_PROG;
      cur.byte_count   = chunk_q;
      cur.last         = (rest_q == '0);
      step             = fpe_pkg::ADDR_W'(chunk_q);
    end else begin
      cur.last = (tot_q == fpe_pkg::TOT_W'(1));
      if (n64_q != '0) begin
        cur.command_kind = fpe_pkg::KIND_E64;
        step             = fpe_pkg::ADDR_W'(1) << fpe_pkg::E64_SHIFT;
      end else if (n32_q) begin
        cur.command_kind = fpe_pkg::KIND_E32;
        step             = fpe_pkg::ADDR_W'(1) << fpe_pkg::E32_SHIFT;
      end else begin
        cur.command_kind = fpe_pkg::KIND_E4;
        step             = fpe_pkg::ADDR_W'(1) << fpe_pkg::E4_SHIFT;
      end
    end
    next_chunk = (rest_q > fpe_pkg::LEN_W'(PAGE_BYTES)) ?
                 fpe_pkg::CNT_W'(PAGE_BYTES) : rest_q[fpe_pkg::CNT_W-1:0];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      type_q <= req_i.req_type;
      addr_q <= req_i.start_address;
      len_q  <= req_i.length;
    end else if (ctrl_i.plan) begin
      single_q      <= plan_reject ||
                       ((type_q == fpe_pkg::REQ_ERASE) && erase_none);
      single_kind_q <= plan_reject ? fpe_pkg::KIND_REJECT : fpe_pkg::KIND_NOTHING;
      chunk_q       <= first_chunk;
      rest_q        <= first_rest;
      n64_q         <= e_n64;
      n32_q         <= e_n32;
      tot_q         <= e_total;
    end else if (ctrl_i.emit) begin
      out_cmd_q <= cur;
      addr_q    <= addr_q + step;
      if (type_q == fpe_pkg::REQ_PROGRAM) begin
        chunk_q <= next_chunk;
        rest_q  <= rest_q - fpe_pkg::LEN_W'(next_chunk);
      end else begin
        tot_q <= tot_q - fpe_pkg::TOT_W'(1);
        if (n64_q != '0) begin
          n64_q <= n64_q - fpe_pkg::N64_W'(1);
        end else if (n32_q) begin
          n32_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.cur_last = cur.last;
  assign out_valid_o     = out_valid_q;
  assign out_cmd_o       = out_cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/flash_program_erase_planner_unit.sv =====
// The request is registered at transfer, planned in the plan state, then its first command
//   is emitted into the output register and shown on out_valid_o. A request giving N
//   commands (N is 1..64) holds the input until its last command is emitted; the sequencer
//   steps one command per cycle into the output register unless the output is stalled.
// Reset: rst_ni asynchronous, active low; clears the sequencer and output valid, no sweep.
`default_nettype none

module flash_program_erase_planner_unit #(
  parameter int PAGE_BYTES    = fpe_pkg::PAGE_BYTES,
  parameter int FLASH_BYTES   = fpe_pkg::FLASH_BYTES,
  parameter int MAX_WRITE_LEN = fpe_pkg::MAX_WRITE_LEN
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // request channel
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire fpe_pkg::fpe_req_t  in_req_i,
  // command channel
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output fpe_pkg::fpe_cmd_t       out_cmd_o
);

  // Controller: idle -> plan -> run. The request is captured on transfer,
  // checked and split in the plan cycle, then one command per free output slot.
  fpe_pkg::fpe_ctrl_t ctrl;
  fpe_pkg::fpe_stat_t stat;

  fpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Datapath: range and length checks, page split for programs,
  // 64K/32K/4K plan for erases, address advance and the output register.
  fpe_datapath #(
    .PAGE_BYTES    (PAGE_BYTES),
    .FLASH_BYTES   (FLASH_BYTES),
    .MAX_WRITE_LEN (MAX_WRITE_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (in_req_i),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_cmd_o   (out_cmd_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fpe_checker.sv =====
`default_nettype none

module fpe_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_stall_o,
  input wire                    out_valid_o,
  input wire                    out_stall_i,
  input wire fpe_pkg::fpe_cmd_t out_cmd_o
);

  // stalled command holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_cmd_o))
    else $error("command changed under stall");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // reject and nothing are single-command answers
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_cmd_o.command_kind == fpe_pkg::KIND_REJECT ||
                    out_cmd_o.command_kind == fpe_pkg::KIND_NOTHING)
    |-> out_cmd_o.last)
    else $error("reject or nothing without last");

  // only programs carry bytes, and never more than a page
  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_cmd_o.command_kind == fpe_pkg::KIND_PROG) ?
      (out_cmd_o.byte_count <= fpe_pkg::CNT_W'(fpe_pkg::PAGE_BYTES)) :
      (out_cmd_o.byte_count == '0))
    else $error("bad byte count");

endmodule

bind flash_program_erase_planner_unit fpe_checker u_fpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_cmd_o   (out_cmd_o)
);

`default_nettype wire
